### rtl/core/obo_pkg.sv
// ----------------------------------------------------------------------------
// obo_pkg
// shared types, widths and constants of the oriented box overlap test
// ----------------------------------------------------------------------------
package obo_pkg;

    localparam int POS_W        = 24;
    localparam int HEAD_W       = 16;
    localparam int DIM_W        = 23;
    localparam int ANG_W        = 32;
    localparam int AXIS_W       = 32;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 24;
    localparam int PROD_W       = POS_W + AXIS_W;
    localparam int PROJ_W       = PROD_W + 1;
    localparam int OFF_W        = 27;

    localparam int DEF_ANGLE_BITS = 16;

    localparam logic [DIM_W-1:0] RST_BOX_WIDTH  = DIM_W'(13107);
    localparam logic [DIM_W-1:0] RST_BOX_LENGTH = DIM_W'(19661);

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);

    // latency of each part, input edge to registered output
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int CORNER_LAT = 3;
    localparam int LANE_LAT   = 5;
    localparam int TOTAL_LAT  = CORDIC_LAT + CORNER_LAT + LANE_LAT + 1;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef enum logic [0:0] {
        CFG_BOX_WIDTH  = 1'b0,
        CFG_BOX_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // arctangent of 2^-i as 32-bit binary angle
    function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2608;
            19:      v = 32'sd1304;
            20:      v = 32'sd652;
            21:      v = 32'sd326;
            22:      v = 32'sd163;
            23:      v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/oriented_box_overlap_sat.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_sat
// separating axis overlap test of two equal oriented rectangles
// ----------------------------------------------------------------------------
// A beat is taken on every cycle that i_start is high; o_busy is always low,
// so one pose pair can enter per clock. Each beat yields exactly one
// o_overlap value, shown for a single cycle with o_strobe high, once it has
// passed the 24-step cordic pipeline, the corner stages, the projection
// lanes and the merge. The receiver cannot stall the result, so it must
// take every strobe. Box width and length are to be written by the user
// through i_cfg_we only while no beat is in flight; no logic enforces this.
// ----------------------------------------------------------------------------
module oriented_box_overlap_sat #(
    parameter int ANGLE_BITS = obo_pkg::DEF_ANGLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  obo_pkg::t_pos               i_own_x,
    input  obo_pkg::t_pos               i_own_y,
    input  logic [obo_pkg::HEAD_W-1:0]  i_own_heading,
    input  obo_pkg::t_pos               i_other_x,
    input  obo_pkg::t_pos               i_other_y,
    input  logic [obo_pkg::HEAD_W-1:0]  i_other_heading,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [obo_pkg::DIM_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_overlap
);
    localparam int LAT  = obo_pkg::TOTAL_LAT;
    localparam int PLAT = obo_pkg::CORDIC_LAT;

    // configuration registers
    logic [obo_pkg::DIM_W-1:0] r_box_width;
    logic [obo_pkg::DIM_W-1:0] r_box_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= obo_pkg::RST_BOX_WIDTH;
            r_box_length <= obo_pkg::RST_BOX_LENGTH;
        end else if (i_cfg_we) begin
            case (obo_pkg::t_cfg_idx'(i_cfg_index))
                obo_pkg::CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data;
                default:                 r_box_length <= i_cfg_data;
            endcase
        end
    end

    // no backpressure: a beat can enter on every cycle
    assign o_busy = 1'b0;

    // beat valid shift line
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start & ~o_busy};
        end
    end

    // centres travel beside the cordic pipeline
    obo_pkg::t_pos r_own_x [PLAT];
    obo_pkg::t_pos r_own_y [PLAT];
    obo_pkg::t_pos r_oth_x [PLAT];
    obo_pkg::t_pos r_oth_y [PLAT];

    always_ff @(posedge i_clk) begin
        r_own_x[0] <= i_own_x;
        r_own_y[0] <= i_own_y;
        r_oth_x[0] <= i_other_x;
        r_oth_y[0] <= i_other_y;
        for (int i = 1; i < PLAT; i++) begin
            r_own_x[i] <= r_own_x[i-1];
            r_own_y[i] <= r_own_y[i-1];
            r_oth_x[i] <= r_oth_x[i-1];
            r_oth_y[i] <= r_oth_y[i-1];
        end
    end

    // heading to cosine and sine
    obo_pkg::t_axis own_c, own_s, oth_c, oth_s;

    obo_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_own (
        .i_clk     (i_clk),
        .i_heading (i_own_heading),
        .o_cos     (own_c),
        .o_sin     (own_s)
    );

    obo_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_oth (
        .i_clk     (i_clk),
        .i_heading (i_other_heading),
        .o_cos     (oth_c),
        .o_sin     (oth_s)
    );

    // corners of both boxes, with the axis terms delayed to match
    obo_pkg::t_pos  own_cx [4];
    obo_pkg::t_pos  own_cy [4];
    obo_pkg::t_pos  oth_cx [4];
    obo_pkg::t_pos  oth_cy [4];
    obo_pkg::t_axis c1, s1, c2, s2;

    obo_corners u_corners_own (
        .i_clk    (i_clk),
        .i_px     (r_own_x[PLAT-1]),
        .i_py     (r_own_y[PLAT-1]),
        .i_cos    (own_c),
        .i_sin    (own_s),
        .i_width  (r_box_width),
        .i_length (r_box_length),
        .o_cx     (own_cx),
        .o_cy     (own_cy),
        .o_cos    (c1),
        .o_sin    (s1)
    );

    obo_corners u_corners_oth (
        .i_clk    (i_clk),
        .i_px     (r_oth_x[PLAT-1]),
        .i_py     (r_oth_y[PLAT-1]),
        .i_cos    (oth_c),
        .i_sin    (oth_s),
        .i_width  (r_box_width),
        .i_length (r_box_length),
        .o_cx     (oth_cx),
        .o_cy     (oth_cy),
        .o_cos    (c2),
        .o_sin    (s2)
    );

    // own corners in slots 0..3, other corners in 4..7
    obo_pkg::t_pos all_cx [8];
    obo_pkg::t_pos all_cy [8];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            all_cx[k]   = own_cx[k];
            all_cy[k]   = own_cy[k];
            all_cx[k+4] = oth_cx[k];
            all_cy[k+4] = oth_cy[k];
        end
    end

    // edge normals of the lanes: own heading, own cross, other heading, other cross
    obo_pkg::t_axis lane_ax [4];
    obo_pkg::t_axis lane_ay [4];

    always_comb begin
        lane_ax[0] = c1;
        lane_ay[0] = s1;
        lane_ax[1] = -s1;
        lane_ay[1] = c1;
        lane_ax[2] = c2;
        lane_ay[2] = s2;
        lane_ax[3] = -s2;
        lane_ay[3] = c2;
    end

    logic [3:0] lane_hit;

    for (genvar a = 0; a < 4; a++) begin : g_lane
        obo_axis_lane u_lane (
            .i_clk (i_clk),
            .i_ax  (lane_ax[a]),
            .i_ay  (lane_ay[a]),
            .i_cx  (all_cx),
            .i_cy  (all_cy),
            .o_hit (lane_hit[a])
        );
    end

    // merge: overlap only when no axis separates the boxes
    logic r_overlap;

    always_ff @(posedge i_clk) begin
        r_overlap <= &lane_hit;
    end

    assign o_overlap = r_overlap;
    assign o_strobe  = r_vld[LAT-1];

`ifndef SYNTHESIS
    // every result traces back to a matching input beat
    a_strobe_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, LAT))
        else $error("result strobe without a matching input beat");

    // every beat taken produces a result strobe
    a_beat_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_strobe)
        else $error("input beat lost in the pipeline");
`endif

endmodule

### rtl/core/obo_cordic.sv
// ----------------------------------------------------------------------------
// obo_cordic
// pipelined rotation cordic, heading to cosine and sine in q2.30
// ----------------------------------------------------------------------------
module obo_cordic #(
    parameter int ANGLE_BITS = obo_pkg::DEF_ANGLE_BITS
) (
    input  logic                         i_clk,
    input  logic [obo_pkg::HEAD_W-1:0]   i_heading,
    output obo_pkg::t_axis               o_cos,
    output obo_pkg::t_axis               o_sin
);
    localparam int N  = obo_pkg::CORDIC_STEPS;
    localparam int CW = obo_pkg::CORDIC_W;
    localparam int AW = obo_pkg::ANG_W;

    logic [AW-1:0] ang_ext;
    logic [AW-1:0] ang;
    logic [AW-1:0] ang_rnd;
    logic [1:0]    quad;
    logic [AW-1:0] resid;

    logic signed [CW-1:0] r_x [N+1];
    logic signed [CW-1:0] r_y [N+1];
    logic signed [AW-1:0] r_z [N+1];
    logic [1:0]           r_q [N+1];
    obo_pkg::t_axis       r_cos;
    obo_pkg::t_axis       r_sin;

    always_comb begin
        ang_ext = AW'(i_heading);
        ang     = (ang_ext & ((AW'(1) << ANGLE_BITS) - AW'(1))) << (AW - ANGLE_BITS);
        ang_rnd = ang + AW'(32'h2000_0000);
        quad    = ang_rnd[AW-1:AW-2];
        resid   = ang - {quad, {(AW-2){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= obo_pkg::CORDIC_X0;
        r_y[0] <= '0;
        r_z[0] <= $signed(resid);
        r_q[0] <= quad;
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!r_z[i][AW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - obo_pkg::atan_turn(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + obo_pkg::atan_turn(i);
            end
            r_q[i+1] <= r_q[i];
        end
    end

    // quadrant by exact swaps and negations
    always_ff @(posedge i_clk) begin
        case (obo_pkg::t_quad'(r_q[N]))
            obo_pkg::QUAD_0: begin
                r_cos <= r_x[N][obo_pkg::AXIS_W-1:0];
                r_sin <= r_y[N][obo_pkg::AXIS_W-1:0];
            end
            obo_pkg::QUAD_1: begin
                r_cos <= -r_y[N][obo_pkg::AXIS_W-1:0];
                r_sin <= r_x[N][obo_pkg::AXIS_W-1:0];
            end
            obo_pkg::QUAD_2: begin
                r_cos <= -r_x[N][obo_pkg::AXIS_W-1:0];
                r_sin <= -r_y[N][obo_pkg::AXIS_W-1:0];
            end
            default: begin
                r_cos <= r_y[N][obo_pkg::AXIS_W-1:0];
                r_sin <= -r_x[N][obo_pkg::AXIS_W-1:0];
            end
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### rtl/core/obo_corners.sv
// ----------------------------------------------------------------------------
// obo_corners
// rotated half extents added to the centre, four saturated corners
// ----------------------------------------------------------------------------
module obo_corners (
    input  logic                        i_clk,
    input  obo_pkg::t_pos               i_px,
    input  obo_pkg::t_pos               i_py,
    input  obo_pkg::t_axis              i_cos,
    input  obo_pkg::t_axis              i_sin,
    input  logic [obo_pkg::DIM_W-1:0]   i_width,
    input  logic [obo_pkg::DIM_W-1:0]   i_length,
    output obo_pkg::t_pos               o_cx [4],
    output obo_pkg::t_pos               o_cy [4],
    output obo_pkg::t_axis              o_cos,
    output obo_pkg::t_axis              o_sin
);
    localparam int PW = obo_pkg::DIM_W + 1 + obo_pkg::AXIS_W;
    localparam int SW = PW + 2;
    localparam int OW = obo_pkg::OFF_W;
    localparam int CW = OW + 1;

    logic signed [PW-1:0] r_wc, r_ls, r_ws, r_lc;
    obo_pkg::t_pos        r_px [2];
    obo_pkg::t_pos        r_py [2];
    obo_pkg::t_axis       r_c [3];
    obo_pkg::t_axis       r_s [3];
    logic signed [OW-1:0] r_ox [4];
    logic signed [OW-1:0] r_oy [4];
    obo_pkg::t_pos        r_cx [4];
    obo_pkg::t_pos        r_cy [4];

    logic signed [obo_pkg::DIM_W:0] w_s, l_s;
    logic signed [SW-1:0] sx [4];
    logic signed [SW-1:0] sy [4];
    logic signed [SW-1:0] rx [4];
    logic signed [SW-1:0] ry [4];
    logic signed [CW-1:0] tx [4];
    logic signed [CW-1:0] ty [4];

    localparam logic signed [CW-1:0] POS_HI = CW'((1 <<< (obo_pkg::POS_W - 1)) - 1);
    localparam logic signed [CW-1:0] POS_LO = -CW'(1 <<< (obo_pkg::POS_W - 1));

    assign w_s = $signed({1'b0, i_width});
    assign l_s = $signed({1'b0, i_length});

    always_ff @(posedge i_clk) begin
        r_wc   <= w_s * i_cos;
        r_ls   <= l_s * i_sin;
        r_ws   <= w_s * i_sin;
        r_lc   <= l_s * i_cos;
        r_px[0] <= i_px;
        r_py[0] <= i_py;
        r_px[1] <= r_px[0];
        r_py[1] <= r_py[0];
        r_c[0] <= i_cos;
        r_s[0] <= i_sin;
        r_c[1] <= r_c[0];
        r_s[1] <= r_s[0];
        r_c[2] <= r_c[1];
        r_s[2] <= r_s[1];
    end

    // corner order: (+w,+l) (-w,+l) (-w,-l) (+w,-l)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic signed [SW-1:0] wc, ls, ws, lc;
            wc = SW'(r_wc);
            ls = SW'(r_ls);
            ws = SW'(r_ws);
            lc = SW'(r_lc);
            if (k == 1 || k == 2) begin
                wc = -wc;
                ws = -ws;
            end
            if (k >= 2) begin
                ls = -ls;
                lc = -lc;
            end
            sx[k] = wc - ls;
            sy[k] = ws + lc;
            rx[k] = (sx[k] + (SW'(1) <<< 30)) >>> 31;
            ry[k] = (sy[k] + (SW'(1) <<< 30)) >>> 31;
            tx[k] = CW'(r_px[1]) + CW'(r_ox[k]);
            ty[k] = CW'(r_py[1]) + CW'(r_oy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_ox[k] <= rx[k][OW-1:0];
            r_oy[k] <= ry[k][OW-1:0];
            if (tx[k] > POS_HI)      r_cx[k] <= POS_HI[obo_pkg::POS_W-1:0];
            else if (tx[k] < POS_LO) r_cx[k] <= POS_LO[obo_pkg::POS_W-1:0];
            else                     r_cx[k] <= tx[k][obo_pkg::POS_W-1:0];
            if (ty[k] > POS_HI)      r_cy[k] <= POS_HI[obo_pkg::POS_W-1:0];
            else if (ty[k] < POS_LO) r_cy[k] <= POS_LO[obo_pkg::POS_W-1:0];
            else                     r_cy[k] <= ty[k][obo_pkg::POS_W-1:0];
        end
    end

    assign o_cx  = r_cx;
    assign o_cy  = r_cy;
    assign o_cos = r_c[2];
    assign o_sin = r_s[2];

endmodule

### rtl/core/obo_axis_lane.sv
// ----------------------------------------------------------------------------
// obo_axis_lane
// projects both boxes on one axis and tests the intervals for overlap
// ----------------------------------------------------------------------------
module obo_axis_lane (
    input  logic            i_clk,
    input  obo_pkg::t_axis  i_ax,
    input  obo_pkg::t_axis  i_ay,
    input  obo_pkg::t_pos   i_cx [8],
    input  obo_pkg::t_pos   i_cy [8],
    output logic            o_hit
);
    localparam int PW = obo_pkg::PROD_W;
    localparam int JW = obo_pkg::PROJ_W;

    logic signed [PW-1:0] r_px [8];
    logic signed [PW-1:0] r_py [8];
    logic signed [JW-1:0] r_p  [8];
    logic signed [JW-1:0] r_lo [4];
    logic signed [JW-1:0] r_hi [4];
    logic signed [JW-1:0] r_lo2 [2];
    logic signed [JW-1:0] r_hi2 [2];
    logic                 r_hit;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_px[k] <= i_ax * i_cx[k];
            r_py[k] <= i_ay * i_cy[k];
            r_p[k]  <= JW'(r_px[k]) + JW'(r_py[k]);
        end
        // pairs 0..1 belong to the own box, 2..3 to the other box
        for (int j = 0; j < 4; j++) begin
            r_lo[j] <= (r_p[2*j+1] < r_p[2*j]) ? r_p[2*j+1] : r_p[2*j];
            r_hi[j] <= (r_p[2*j+1] > r_p[2*j]) ? r_p[2*j+1] : r_p[2*j];
        end
        for (int b = 0; b < 2; b++) begin
            r_lo2[b] <= (r_lo[2*b+1] < r_lo[2*b]) ? r_lo[2*b+1] : r_lo[2*b];
            r_hi2[b] <= (r_hi[2*b+1] > r_hi[2*b]) ? r_hi[2*b+1] : r_hi[2*b];
        end
        // touching intervals do not count
        r_hit <= (r_lo2[0] < r_hi2[1]) && (r_lo2[1] < r_hi2[0]);
    end

    assign o_hit = r_hit;

endmodule
